// ===== hw/rtl/swept_circle_hit_test_macros.svh =====
// Assertion helpers for the swept circle hit test.
`ifndef SWEPT_CIRCLE_HIT_TEST_MACROS_SVH
`define SWEPT_CIRCLE_HIT_TEST_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SCHT_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SCHT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/scht_pkg.sv =====
package scht_pkg;

    localparam int MAX_STEPS_DEF = 64;
    localparam int TRIG_ITER_DEF = 16;
    localparam int ATAN_N = 24;
    localparam int QUEUE_DEPTH = 2;
    localparam logic signed [32:0] CORDIC_GAIN = 33'sh026DD3B6A;

    typedef struct packed {
        logic signed [15:0] mx;
        logic signed [15:0] my;
        logic signed [15:0] tx;
        logic signed [15:0] ty;
        logic [12:0]        r;
        logic [11:0]        spd;
        logic               sweep;
        logic signed [34:0] px;
        logic signed [34:0] py;
        logic signed [31:0] dcx;
        logic signed [31:0] dcy;
    } scht_job_t;

    typedef enum logic [2:0] {
        F_IDLE,
        F_ROT,
        F_ROUND,
        F_MUL_START,
        F_MUL_STEP,
        F_PUSH
    } scht_fstate_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_SEL,
        B_SQ,
        B_CMP
    } scht_bstate_t;

    function automatic logic [31:0] atan_turn(input logic [4:0] idx);
        logic [31:0] v;
        begin
            case (idx)
                5'd0:    v = 32'h20000000;
                5'd1:    v = 32'h12E4051E;
                5'd2:    v = 32'h09FB385B;
                5'd3:    v = 32'h051111D4;
                5'd4:    v = 32'h028B0D43;
                5'd5:    v = 32'h0145D7E1;
                5'd6:    v = 32'h00A2F61E;
                5'd7:    v = 32'h00517C55;
                5'd8:    v = 32'h0028BE53;
                5'd9:    v = 32'h00145F2F;
                5'd10:   v = 32'h000A2F98;
                5'd11:   v = 32'h000517CC;
                5'd12:   v = 32'h00028BE6;
                5'd13:   v = 32'h000145F3;
                5'd14:   v = 32'h0000A2FA;
                5'd15:   v = 32'h0000517D;
                5'd16:   v = 32'h000028BE;
                5'd17:   v = 32'h0000145F;
                5'd18:   v = 32'h00000A30;
                5'd19:   v = 32'h00000518;
                5'd20:   v = 32'h0000028C;
                5'd21:   v = 32'h00000146;
                5'd22:   v = 32'h000000A3;
                5'd23:   v = 32'h00000051;
                default: v = 32'h00000000;
            endcase
            return v;
        end
    endfunction

endpackage

// ===== hw/rtl/swept_circle_hit_test.sv =====
// The front end runs the CORDIC rotation, rounding and two multiply steps on a start transfer
// before it pushes the item, or goes straight to the push without a sweep; the push waits while
// the queue is full. The back end tests up to MAX_STEPS + 1 path points and then strobes done;
// a quick reject of a point takes a single squaring step. Throughput: the distance test loop sets it,
// while a two entry queue lets the CORDIC front end work on the next item meanwhile.
// Reset clears the control state only; results are strobed on done and cannot be stalled.
module swept_circle_hit_test #(
    parameter int MAX_STEPS = scht_pkg::MAX_STEPS_DEF,
    parameter int TRIG_ITERATIONS = scht_pkg::TRIG_ITER_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [15:0] mover_x,
    input  logic signed [15:0] mover_y,
    input  logic signed [15:0] target_x,
    input  logic signed [15:0] target_y,
    input  logic [11:0]        mover_radius,
    input  logic [11:0]        target_radius,
    input  logic [11:0]        speed,
    input  logic [15:0]        heading,
    output logic               done,
    output logic               hit
);
    import scht_pkg::*;
    `include "swept_circle_hit_test_macros.svh"

    logic      push, full, pop, empty;
    scht_job_t push_job, head_job;

    scht_front #(
        .TRIG_ITERATIONS(TRIG_ITERATIONS)
    ) u_front (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .mover_x(mover_x),
        .mover_y(mover_y),
        .target_x(target_x),
        .target_y(target_y),
        .mover_radius(mover_radius),
        .target_radius(target_radius),
        .speed(speed),
        .heading(heading),
        .busy(busy),
        .push(push),
        .job(push_job),
        .full(full)
    );

    scht_queue u_queue (
        .clk(clk),
        .rst_n(rst_n),
        .push(push),
        .push_job(push_job),
        .full(full),
        .pop(pop),
        .head_job(head_job),
        .empty(empty)
    );

    scht_back #(
        .MAX_STEPS(MAX_STEPS)
    ) u_back (
        .clk(clk),
        .rst_n(rst_n),
        .empty(empty),
        .head_job(head_job),
        .pop(pop),
        .done(done),
        .hit(hit)
    );

    `SCHT_ASSERT_SAME(a_no_overflow, push, !full, "Queue transfer while full.")
    `SCHT_ASSERT_SAME(a_no_underflow, pop, !empty, "Queue pop while empty.")
    `SCHT_ASSERT_NEXT(a_done_single, done, !done, "Result strobes back to back.")

endmodule

// ===== hw/rtl/scht_front.sv =====
module scht_front #(
    parameter int TRIG_ITERATIONS = scht_pkg::TRIG_ITER_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [15:0] mover_x,
    input  logic signed [15:0] mover_y,
    input  logic signed [15:0] target_x,
    input  logic signed [15:0] target_y,
    input  logic [11:0]        mover_radius,
    input  logic [11:0]        target_radius,
    input  logic [11:0]        speed,
    input  logic [15:0]        heading,
    output logic               busy,
    output logic               push,
    output scht_pkg::scht_job_t job,
    input  logic               full
);
    import scht_pkg::*;

    localparam int ITER = (TRIG_ITERATIONS < ATAN_N) ? TRIG_ITERATIONS : ATAN_N;
    localparam logic [4:0] LAST_ITER = 5'(ITER - 1);

    scht_fstate_t       state_reg, state_next;
    scht_job_t          job_reg, job_next;
    logic signed [32:0] x_reg, x_next, y_reg, y_next, z_reg, z_next;
    logic [4:0]         i_reg, i_next;
    logic [1:0]         quad_reg, quad_next;
    logic signed [17:0] cs_reg, cs_next, sn_reg, sn_next;

    logic               accept;
    logic [12:0]        r_sum;
    logic signed [32:0] xs, ys, at, xr, yr;
    logic signed [17:0] xq, yq;
    logic signed [13:0] mul_k;
    logic signed [31:0] prod_x, prod_y;

    assign accept = start && (state_reg == F_IDLE);
    assign r_sum = {1'b0, mover_radius} + {1'b0, target_radius};
    assign xs = x_reg >>> i_reg;
    assign ys = y_reg >>> i_reg;
    assign at = $signed({1'b0, atan_turn(i_reg)});
    assign xr = (x_reg + 33'sd8192) >>> 14;
    assign yr = (y_reg + 33'sd8192) >>> 14;
    assign xq = xr[17:0];
    assign yq = yr[17:0];
    assign mul_k = (state_reg == F_MUL_START) ? $signed({2'b00, job_reg.spd})
                                              : $signed({1'b0, job_reg.r});
    assign prod_x = mul_k * cs_reg;
    assign prod_y = mul_k * sn_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            F_IDLE:
            begin
                if (start)
                begin
                    state_next = ({1'b0, speed} > r_sum) ? F_ROT : F_PUSH;
                end
            end
            F_ROT:
            begin
                if (i_reg == LAST_ITER)
                begin
                    state_next = F_ROUND;
                end
            end
            F_ROUND:     state_next = F_MUL_START;
            F_MUL_START: state_next = F_MUL_STEP;
            F_MUL_STEP:  state_next = F_PUSH;
            F_PUSH:
            begin
                if (!full)
                begin
                    state_next = F_IDLE;
                end
            end
            default:     state_next = F_IDLE;
        endcase
    end

    always_comb
    begin
        job_next = job_reg;
        x_next = x_reg;
        y_next = y_reg;
        z_next = z_reg;
        i_next = i_reg;
        quad_next = quad_reg;
        cs_next = cs_reg;
        sn_next = sn_reg;
        if (accept)
        begin
            job_next.mx = mover_x;
            job_next.my = mover_y;
            job_next.tx = target_x;
            job_next.ty = target_y;
            job_next.r = r_sum;
            job_next.spd = speed;
            job_next.sweep = {1'b0, speed} > r_sum;
            x_next = CORDIC_GAIN;
            y_next = '0;
            z_next = $signed({3'b000, heading[13:0], 16'h0000});
            quad_next = heading[15:14];
            i_next = '0;
        end
        if (state_reg == F_ROT)
        begin
            if (!z_reg[32])
            begin
                x_next = x_reg - ys;
                y_next = y_reg + xs;
                z_next = z_reg - at;
            end
            else
            begin
                x_next = x_reg + ys;
                y_next = y_reg - xs;
                z_next = z_reg + at;
            end
            i_next = i_reg + 5'd1;
        end
        if (state_reg == F_ROUND)
        begin
            case (quad_reg)
                2'd1:
                begin
                    cs_next = -yq;
                    sn_next = xq;
                end
                2'd2:
                begin
                    cs_next = -xq;
                    sn_next = -yq;
                end
                2'd3:
                begin
                    cs_next = yq;
                    sn_next = -xq;
                end
                default:
                begin
                    cs_next = xq;
                    sn_next = yq;
                end
            endcase
        end
        if (state_reg == F_MUL_START)
        begin
            job_next.px = $signed({{3{job_reg.mx[15]}}, job_reg.mx, 16'h0000})
                          - {{3{prod_x[31]}}, prod_x};
            job_next.py = $signed({{3{job_reg.my[15]}}, job_reg.my, 16'h0000})
                          - {{3{prod_y[31]}}, prod_y};
        end
        if (state_reg == F_MUL_STEP)
        begin
            job_next.dcx = prod_x;
            job_next.dcy = prod_y;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg <= job_next;
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
        i_reg <= i_next;
        quad_reg <= quad_next;
        cs_reg <= cs_next;
        sn_reg <= sn_next;
    end

    assign busy = (state_reg != F_IDLE);
    assign push = (state_reg == F_PUSH) && !full;
    assign job = job_reg;

endmodule

// ===== hw/rtl/scht_queue.sv =====
module scht_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  scht_pkg::scht_job_t push_job,
    output logic                full,
    input  logic                pop,
    output scht_pkg::scht_job_t head_job,
    output logic                empty
);
    import scht_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    scht_job_t          mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_reg, rd_reg;
    logic [CNT_W-1:0]   cnt_reg;

    assign full = (cnt_reg == CNT_W'(QUEUE_DEPTH));
    assign empty = (cnt_reg == '0);
    assign head_job = mem[rd_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg <= '0;
            rd_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= (wr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_reg <= (rd_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_reg + 1'b1;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule

// ===== hw/rtl/scht_back.sv =====
module scht_back #(
    parameter int MAX_STEPS = scht_pkg::MAX_STEPS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                empty,
    input  scht_pkg::scht_job_t head_job,
    output logic                pop,
    output logic                done,
    output logic                hit
);
    import scht_pkg::*;

    localparam int JW = $clog2(MAX_STEPS + 1);
    localparam int JRW = JW + 13;

    scht_bstate_t       state_reg, state_next;
    scht_job_t          job_reg;
    logic signed [34:0] px_reg, py_reg;
    logic [JW-1:0]      j_reg;
    logic [JRW-1:0]     jr_reg;
    logic [28:0]        ax_reg, ay_reg;
    logic               rej_reg, last_reg;
    logic [1:0]         k_reg;
    logic [58:0]        acc_reg;
    logic [57:0]        rr2_reg;
    logic               done_reg, hit_reg;

    logic               more;
    logic signed [34:0] ptx, pty, dx, dy;
    logic [34:0]        adx, ady, rq;
    logic [13:0]        hx, hy;
    logic [14:0]        lx, ly;
    logic [29:0]        mx_a, mx_b;
    logic [57:0]        term_x, term_y;
    logic               in_hit;

    assign more = job_reg.sweep && (j_reg < JW'(MAX_STEPS))
                  && (jr_reg < JRW'(job_reg.spd));
    assign ptx = more ? px_reg : $signed({{3{job_reg.mx[15]}}, job_reg.mx, 16'h0000});
    assign pty = more ? py_reg : $signed({{3{job_reg.my[15]}}, job_reg.my, 16'h0000});
    assign dx = ptx - $signed({{3{job_reg.tx[15]}}, job_reg.tx, 16'h0000});
    assign dy = pty - $signed({{3{job_reg.ty[15]}}, job_reg.ty, 16'h0000});
    assign adx = dx[34] ? 35'(-dx) : 35'(dx);
    assign ady = dy[34] ? 35'(-dy) : 35'(dy);
    assign rq = {6'b0, job_reg.r, 16'h0000};

    assign hx = ax_reg[28:15];
    assign lx = ax_reg[14:0];
    assign hy = ay_reg[28:15];
    assign ly = ay_reg[14:0];

    always_comb
    begin
        case (k_reg)
            2'd0:
            begin
                mx_a = {2'b00, hx} * {2'b00, hx};
                mx_b = {2'b00, hy} * {2'b00, hy};
                term_x = {mx_a[27:0], 30'h0};
                term_y = {mx_b[27:0], 30'h0};
            end
            2'd1:
            begin
                mx_a = {1'b0, hx} * lx;
                mx_b = {1'b0, hy} * ly;
                term_x = {13'h0, mx_a[28:0], 16'h0};
                term_y = {13'h0, mx_b[28:0], 16'h0};
            end
            default:
            begin
                mx_a = lx * lx;
                mx_b = ly * ly;
                term_x = {28'h0, mx_a};
                term_y = {28'h0, mx_b};
            end
        endcase
    end

    assign in_hit = !rej_reg && (acc_reg < {1'b0, rr2_reg});

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE:
            begin
                if (!empty)
                begin
                    state_next = B_SEL;
                end
            end
            B_SEL:
            begin
                state_next = B_SQ;
            end
            B_SQ:
            begin
                if (rej_reg || (k_reg == 2'd2))
                begin
                    state_next = B_CMP;
                end
            end
            B_CMP:
            begin
                state_next = (in_hit || last_reg) ? B_IDLE : B_SEL;
            end
            default: state_next = B_IDLE;
        endcase
    end

    assign pop = (state_reg == B_IDLE) && !empty;

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            B_IDLE:
            begin
                job_reg <= head_job;
                px_reg <= head_job.px;
                py_reg <= head_job.py;
                j_reg <= '0;
                jr_reg <= '0;
                rr2_reg <= {26'(head_job.r * head_job.r), 32'h0};
            end
            B_SEL:
            begin
                ax_reg <= adx[28:0];
                ay_reg <= ady[28:0];
                rej_reg <= (job_reg.r == '0) || (adx >= rq) || (ady >= rq);
                last_reg <= !more;
                k_reg <= '0;
                acc_reg <= '0;
            end
            B_SQ:
            begin
                acc_reg <= acc_reg + {1'b0, term_x} + {1'b0, term_y};
                k_reg <= k_reg + 2'd1;
            end
            B_CMP:
            begin
                j_reg <= j_reg + 1'b1;
                jr_reg <= jr_reg + JRW'(job_reg.r);
                px_reg <= px_reg + {{3{job_reg.dcx[31]}}, job_reg.dcx};
                py_reg <= py_reg + {{3{job_reg.dcy[31]}}, job_reg.dcy};
            end
            default:
            begin
                k_reg <= '0;
            end
        endcase
        hit_reg <= in_hit;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            done_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg <= (state_reg == B_CMP) && (in_hit || last_reg);
        end
    end

    assign done = done_reg;
    assign hit = hit_reg;

endmodule
